// ===== src/sonco_pkg.sv =====
// Shared types, constants and the arctangent table of the sine oscillator.
// No dependencies; every other file but sonco_ram refers to it by scoped names.
package sonco_pkg;

  localparam int PHASE_BITS_DEFAULT  = 32;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam int STEP_BITS = 32;
  localparam int GAIN_BITS = 24;
  localparam int CFG_BITS  = 32;
  localparam int ANG_BITS  = 32;

  localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 32'd39370534;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET       = 24'd4194304;
  localparam logic [GAIN_BITS-1:0] GAIN_FULL        = 24'd8388608;

  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_X0    = 34'sd652032874;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] ROUND_Q23    = 34'sd64;
  localparam logic signed [CW-1:0] SINE_MAX     = 34'sd8388608;

  typedef enum logic [0:0] {
    REG_PHASE_STEP = 1'b0,
    REG_GAIN       = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic                valid;
    logic [ANG_BITS-1:0] ang;
  } angle_req_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] y;
  } sine_res_t;

  function automatic logic [ANG_BITS-1:0] turn_atan(input int idx);
    logic [ANG_BITS-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== src/sine_oscillator_nco.sv =====
// Sine oscillator top level: configuration registers, phase RAM, CORDIC, scaling
// and a two-entry output buffer. Depends on sonco_pkg and all sonco_* modules.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  in      | in_valid / in_stall   | tick (1 bit)
//  out     | out_valid / out_stall | sample (SAMPLE_BITS, signed)
//  cfg     | cfg_write             | cfg_index, cfg_data (32 bits)
//
// One request per cycle while in_stall is low; each tick that is taken yields a sample.
// The rate is set by the phase read-add-write loop on the one-entry RAM, which
// forwards the value written in the previous cycle.
// Reset clears control state; the phase reads as zero until its first write.
// Output stall fills the output register then a skid entry; in_stall rises
// only when both are full, and holds the whole pipeline.
module sine_oscillator_nco #(
  parameter int PHASE_BITS  = sonco_pkg::PHASE_BITS_DEFAULT,
  parameter int SAMPLE_BITS = sonco_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             tick,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic                             cfg_write,
  input  sonco_pkg::cfg_index_t            cfg_index,
  input  logic [sonco_pkg::CFG_BITS-1:0]   cfg_data
);

  logic [sonco_pkg::STEP_BITS-1:0] phase_step;
  logic [sonco_pkg::GAIN_BITS-1:0] gain;
  logic                            skid_full;
  logic [SAMPLE_BITS-1:0]          skid_sample;
  logic                            advance;
  logic                            accept;
  logic                            pop;
  logic                            res_valid;
  logic [SAMPLE_BITS-1:0]          res_sample;
  sonco_pkg::angle_req_t           req;
  sonco_pkg::sine_res_t            sine;

  assign in_stall = skid_full;
  assign advance  = !skid_full;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= sonco_pkg::PHASE_STEP_RESET;
      gain       <= sonco_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sonco_pkg::REG_PHASE_STEP: phase_step <= cfg_data;
        sonco_pkg::REG_GAIN:       gain <= cfg_data[sonco_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  sonco_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst        (rst),
    .adv        (accept && tick),
    .phase_step (phase_step),
    .req        (req)
  );

  sonco_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .res     (sine)
  );

  sonco_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .gain       (gain),
    .sine       (sine),
    .res_valid  (res_valid),
    .res_sample (res_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (pop) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_full <= 1'b1;
    end
    if (skid_full) begin
      if (pop) begin
        sample <= skid_sample;
      end
    end else if (!out_valid || pop) begin
      if (res_valid) begin
        sample <= res_sample;
      end
    end else if (res_valid) begin
      skid_sample <= res_sample;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry held without an output request");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !out_stall) |=> (!skid_full && out_valid))
    else $error("skid entry not moved to the output register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_full))
    else $error("output buffer not empty after reset");

endmodule

// ===== src/sonco_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sonco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sonco_phase.sv =====
// Phase accumulator held in a one-entry RAM: read, add the tuning word, write back.
// Depends on sonco_pkg and sonco_ram.
module sonco_phase #(
  parameter int PHASE_BITS = sonco_pkg::PHASE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [sonco_pkg::STEP_BITS-1:0]   phase_step,
  output sonco_pkg::angle_req_t             req
);

  localparam int SUM_BITS = (PHASE_BITS > sonco_pkg::STEP_BITS) ? PHASE_BITS
                                                               : sonco_pkg::STEP_BITS;

  logic [PHASE_BITS-1:0] rdata;
  logic [PHASE_BITS-1:0] fwd;
  logic [PHASE_BITS-1:0] cur;
  logic [PHASE_BITS-1:0] phase_next;
  logic [SUM_BITS-1:0]   sum;
  logic                  phase_valid;
  logic                  wrote_last;
  logic [sonco_pkg::ANG_BITS-1:0] ang;

  sonco_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (1)
  ) u_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (1'b0),
    .wdata (phase_next),
    .raddr (1'b0),
    .rdata (rdata)
  );

  always_comb begin
    if (!phase_valid) begin
      cur = '0;
    end else if (wrote_last) begin
      cur = fwd;
    end else begin
      cur = rdata;
    end
    sum        = SUM_BITS'(cur) + SUM_BITS'(phase_step);
    phase_next = sum[PHASE_BITS-1:0];
  end

  generate
    if (PHASE_BITS >= sonco_pkg::ANG_BITS) begin : g_ang_top
      assign ang = cur[PHASE_BITS-1 -: sonco_pkg::ANG_BITS];
    end else begin : g_ang_shift
      assign ang = {cur, {(sonco_pkg::ANG_BITS - PHASE_BITS){1'b0}}};
    end
  endgenerate

  assign req.valid = adv;
  assign req.ang   = ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_valid <= 1'b0;
      wrote_last  <= 1'b0;
    end else begin
      wrote_last <= adv;
      if (adv) begin
        phase_valid <= 1'b1;
      end
    end
    if (adv) begin
      fwd <= phase_next;
    end
  end

endmodule

// ===== src/sonco_cordic.sv =====
// Pipelined rotation-mode CORDIC: quadrant fold, then one micro-rotation per stage.
// Depends on sonco_pkg.
module sonco_cordic (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  sonco_pkg::angle_req_t  req,
  output sonco_pkg::sine_res_t   res
);

  localparam int N  = sonco_pkg::CORDIC_STEPS;
  localparam int CW = sonco_pkg::CW;

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic signed [CW-1:0] zs [0:N];
  logic                 vs [0:N];
  logic signed [CW-1:0] z_raw;
  logic signed [CW-1:0] z_fold;

  always_comb begin
    z_raw = {{(CW - sonco_pkg::ANG_BITS){req.ang[sonco_pkg::ANG_BITS-1]}}, req.ang};
    if (z_raw > sonco_pkg::QUARTER_TURN) begin
      z_fold = sonco_pkg::HALF_TURN - z_raw;
    end else if (z_raw < -sonco_pkg::QUARTER_TURN) begin
      z_fold = -sonco_pkg::HALF_TURN - z_raw;
    end else begin
      z_fold = z_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (advance) begin
      vs[0] <= req.valid;
    end
    if (advance) begin
      xs[0] <= sonco_pkg::CORDIC_X0;
      ys[0] <= '0;
      zs[0] <= z_fold;
    end
  end

  generate
    for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [CW-1:0] ATAN =
        CW'(signed'({1'b0, sonco_pkg::turn_atan(i)}));
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      assign dx = ys[i] >>> i;
      assign dy = xs[i] >>> i;

      always_ff @(posedge clk) begin
        if (rst) begin
          vs[i+1] <= 1'b0;
        end else if (advance) begin
          vs[i+1] <= vs[i];
        end
        if (advance) begin
          if (zs[i] >= 0) begin
            xs[i+1] <= xs[i] - dx;
            ys[i+1] <= ys[i] + dy;
            zs[i+1] <= zs[i] - ATAN;
          end else begin
            xs[i+1] <= xs[i] + dx;
            ys[i+1] <= ys[i] - dy;
            zs[i+1] <= zs[i] + ATAN;
          end
        end
      end
    end
  endgenerate

  assign res.valid = vs[N];
  assign res.y     = ys[N];

endmodule

// ===== src/sonco_scale.sv =====
// Round the sine to Q1.23, clamp, apply the gain and full scale, restore the sign.
// Depends on sonco_pkg.
module sonco_scale #(
  parameter int SAMPLE_BITS = sonco_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [sonco_pkg::GAIN_BITS-1:0]   gain,
  input  sonco_pkg::sine_res_t              sine,
  output logic                              res_valid,
  output logic [SAMPLE_BITS-1:0]            res_sample
);

  localparam int CW  = sonco_pkg::CW;
  localparam int MB  = 24;
  localparam int GMB = 47;
  localparam int FB  = SAMPLE_BITS - 1;
  localparam int AB  = 24 + FB;
  localparam int BB  = 23 + FB;
  localparam int TB  = SAMPLE_BITS + 46;
  localparam logic [FB-1:0] FULL_SCALE = {FB{1'b1}};

  logic signed [CW-1:0] s_round;
  logic signed [CW-1:0] s_clamp;
  logic signed [CW-1:0] s_abs;
  logic [MB-1:0]        g_sat;
  logic [2*MB-1:0]      gm_full;
  logic [TB-1:0]        total;
  logic [SAMPLE_BITS-1:0] mag;

  logic           v1, v2, v3;
  logic           n1, n2, n3;
  logic [MB-1:0]  m1;
  logic [GMB-1:0] gm2;
  logic [AB-1:0]  a3;
  logic [BB-1:0]  b3;

  always_comb begin
    s_round = (sine.y + sonco_pkg::ROUND_Q23) >>> 7;
    if (s_round > sonco_pkg::SINE_MAX) begin
      s_clamp = sonco_pkg::SINE_MAX;
    end else if (s_round < -sonco_pkg::SINE_MAX) begin
      s_clamp = -sonco_pkg::SINE_MAX;
    end else begin
      s_clamp = s_round;
    end
    s_abs   = s_clamp[CW-1] ? -s_clamp : s_clamp;
    g_sat   = (gain > sonco_pkg::GAIN_FULL) ? sonco_pkg::GAIN_FULL : gain;
    gm_full = g_sat * m1;
    total   = {a3, 23'b0} + TB'(b3);
    mag     = total[TB-1 -: SAMPLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      v1        <= sine.valid;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
    if (advance) begin
      n1         <= s_clamp[CW-1];
      m1         <= s_abs[MB-1:0];
      n2         <= n1;
      gm2        <= gm_full[GMB-1:0];
      n3         <= n2;
      a3         <= AB'(gm2[GMB-1:23] * FULL_SCALE);
      b3         <= BB'(gm2[22:0] * FULL_SCALE);
      res_sample <= n3 ? (~mag + 1'b1) : mag;
    end
  end

endmodule

// ===== tb/sine_oscillator_nco_test.sv =====
// Self-checking testbench for sine_oscillator_nco: ticks and register writes are driven
// against a bit-exact phase accumulator and CORDIC sine predictor held in a scoreboard.
// Depends on sonco_pkg and the sine_oscillator_nco RTL.
`timescale 1ns / 1ps

module sine_oscillator_nco_test;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SAMPLE_REQS  = 600;

  class nco_scoreboard;
    bit [31:0]                     phase_acc;
    bit [31:0]                     step;
    bit [sonco_pkg::GAIN_BITS-1:0] gain_reg;
    bit [31:0]                     atan_turn[30];
    bit [23:0]                     sample_q[$];
    int                            errors;
    int                            checked;

    function new();
      atan_turn = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
      phase_acc = '0;
      step      = sonco_pkg::PHASE_STEP_RESET;
      gain_reg  = sonco_pkg::GAIN_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(sonco_pkg::cfg_index_t idx,
                            logic [sonco_pkg::CFG_BITS-1:0] data);
      case (idx)
        sonco_pkg::REG_PHASE_STEP: step = data;
        sonco_pkg::REG_GAIN:       gain_reg = data[sonco_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Sine of a 32-bit turn angle in Q1.23, clamped to plus or minus full scale.
    function longint sine_q23(bit [31:0] ang);
      longint z, x, y, dx, dy, s;
      z = longint'({32'b0, ang});
      x = 64'sd652032874;
      y = 0;
      if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
      if (z > (64'sd1 <<< 30)) z = (64'sd1 <<< 31) - z;
      else if (z < -(64'sd1 <<< 30)) z = -(64'sd1 <<< 31) - z;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'({32'b0, atan_turn[i]});
        end else begin
          x += dx;
          y -= dy;
          z += longint'({32'b0, atan_turn[i]});
        end
      end
      s = (y + 64) >>> 7;
      if (s > 64'sd8388608) s = 64'sd8388608;
      if (s < -64'sd8388608) s = -64'sd8388608;
      return s;
    endfunction

    function void note_tick(logic t);
      longint     s;
      bit         neg;
      bit [127:0] prod;
      bit [63:0]  mag;
      bit [63:0]  g;
      if (!t) return;
      s    = sine_q23(phase_acc);
      neg  = s < 0;
      g    = (gain_reg > sonco_pkg::GAIN_FULL) ? 64'(sonco_pkg::GAIN_FULL) : 64'(gain_reg);
      prod = 128'(g) * 128'(neg ? -s : s) * 128'((64'd1 << 23) - 1);
      mag  = 64'(prod >> 46);
      sample_q.push_back(neg ? 24'(-mag) : 24'(mag));
      phase_acc += step;
    endfunction

    function void check_sample(logic [23:0] got);
      bit [23:0] want;
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got %0d", $time, $signed(got));
        errors++;
        return;
      end
      want = sample_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: sample mismatch, expected %0d, got %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function int pending();
      return sample_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           tick = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [23:0]             sample;
  logic                           cfg_write = 1'b0;
  sonco_pkg::cfg_index_t          cfg_index = sonco_pkg::REG_PHASE_STEP;
  logic [sonco_pkg::CFG_BITS-1:0] cfg_data = '0;

  nco_scoreboard sb = new();
  int  cycle_count = 0;
  int  sample_reqs = 0;
  int  idle_reqs   = 0;
  int  reg_writes  = 0;
  int  stall_left  = 0;
  bit  quiet       = 1'b0;
  bit  no_gaps     = 1'b0;

  sine_oscillator_nco dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tick      (tick),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count, sb.pending());
      $display("sine_oscillator_nco_test: FAIL");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_tick(tick);
        if (tick) sample_reqs++;
        else idle_reqs++;
      end
      if (out_valid && !out_stall) sb.check_sample(sample);
      if (cfg_write) begin
        sb.write_reg(cfg_index, cfg_data);
        reg_writes++;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet) begin
      out_stall  <= 1'b0;
      stall_left = 4;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    end
  end

  task automatic send_request(input logic t);
    in_valid <= 1'b1;
    tick     <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
        ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    if (!no_gaps && n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_samples();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain_samples();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input sonco_pkg::cfg_index_t idx,
                           input logic [sonco_pkg::CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_burst(input int n);
    for (int i = 0; i < n; i++) begin
      send_request(1'b1);
      idle_gap();
    end
  endtask

  initial begin
    logic [sonco_pkg::CFG_BITS-1:0] data;
    int                             len;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration, an idle tick in the middle
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    settle();
    // land the phase exactly on a quarter turn, then walk the quadrants at full gain
    write_reg(sonco_pkg::REG_PHASE_STEP, 32'h40000000 - 2 * sonco_pkg::PHASE_STEP_RESET);
    write_reg(sonco_pkg::REG_GAIN, 32'hFF800000);
    send_request(1'b1);
    settle();
    write_reg(sonco_pkg::REG_PHASE_STEP, 32'h40000000);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_burst(3);
    settle();
    write_reg(sonco_pkg::REG_GAIN, 32'hFFFFFFFF);
    send_burst(2);
    settle();
    write_reg(sonco_pkg::REG_GAIN, 32'h0);
    send_burst(2);
    settle();
    write_reg(sonco_pkg::REG_PHASE_STEP, 32'hFFFFFFFF);
    write_reg(sonco_pkg::REG_GAIN, 32'h1);
    send_burst(3);
    settle();
    write_reg(sonco_pkg::REG_PHASE_STEP, 32'h0);
    write_reg(sonco_pkg::REG_GAIN, 32'h00800001);
    send_burst(2);
    settle();
    write_reg(sonco_pkg::REG_PHASE_STEP, 32'h40000001);
    write_reg(sonco_pkg::REG_GAIN, 32'h00800000);
    send_burst(4);

    while (sample_reqs < SAMPLE_REQS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0: data = $urandom;
          1: data = $urandom_range(1, 1 << 20);
          2: data = -$urandom_range(1, 1 << 20);
          3: data = ($urandom_range(0, 15) << 28) + $urandom_range(0, 3) - 1;
          default: data = '0;
        endcase
        write_reg(sonco_pkg::REG_PHASE_STEP, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = $urandom;
        case ($urandom_range(0, 5))
          0:       data[23:0] = 24'($urandom_range(sonco_pkg::GAIN_FULL + 1, 24'hFFFFFF));
          1:       data[23:0] = sonco_pkg::GAIN_FULL;
          2:       data[23:0] = 24'($urandom_range(0, 255));
          default: data[23:0] = 24'($urandom_range(0, sonco_pkg::GAIN_FULL));
        endcase
        write_reg(sonco_pkg::REG_GAIN, data);
      end
      quiet   = ($urandom_range(0, 3) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      len     = $urandom_range(30, 80);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && $urandom_range(0, 2) == 0) drain_samples();
        send_request($urandom_range(0, 9) != 0);
        idle_gap();
      end
    end

    quiet = 1'b0;
    drain_samples();
    repeat (DRAIN_CYCLES + 10) @(posedge clk);
    $display("%0d sample requests and %0d idle ticks under %0d register writes;",
             sample_reqs, idle_reqs, reg_writes);
    $display("%0d samples checked, %0d errors, %0d outstanding",
             sb.checked, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sine_oscillator_nco_test: PASS");
    end else begin
      $display("sine_oscillator_nco_test: FAIL");
    end
    $finish;
  end

endmodule
